// ----- hdl/stack_machine_executor_top_macros.svh -----
// assertion macros for the stack machine executor
// used by stack_machine_executor_top.sv; expects clk and rst in scope
`ifndef STACK_MACHINE_EXECUTOR_TOP_MACROS_SVH
`define STACK_MACHINE_EXECUTOR_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define SMX_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define SMX_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/smx_pkg.sv -----
// shared types and constants of the stack machine executor
// no dependencies
`default_nettype none

package smx_pkg;

  localparam int unsigned SMX_STACK_DEPTH = 256;
  localparam int unsigned SMX_WORD_W      = 32;

  // opcodes
  localparam logic [SMX_WORD_W-1:0] OP_PUSH  = 32'd1;
  localparam logic [SMX_WORD_W-1:0] OP_ADD   = 32'd2;
  localparam logic [SMX_WORD_W-1:0] OP_SUB   = 32'd3;
  localparam logic [SMX_WORD_W-1:0] OP_DIV   = 32'd4;
  localparam logic [SMX_WORD_W-1:0] OP_MUL   = 32'd5;
  localparam logic [SMX_WORD_W-1:0] OP_IN    = 32'd7;
  localparam logic [SMX_WORD_W-1:0] OP_PRINT = 32'd8;
  localparam logic [SMX_WORD_W-1:0] OP_OUT   = 32'd9;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_PRINTED  = 3'd1,
    ST_HALTED   = 3'd2,
    ST_BADSTART = 3'd3,
    ST_UNDER    = 3'd4,
    ST_OVER     = 3'd5,
    ST_DIVZERO  = 3'd6,
    ST_IGNORED  = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    PH_FIRST   = 2'd0,
    PH_LITERAL = 2'd1,
    PH_COMMAND = 2'd2,
    PH_HALT    = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_RD_TOP,
    S_EXEC,
    S_DIV,
    S_WB,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic                  start;
    logic [SMX_WORD_W-1:0] num;
    logic [SMX_WORD_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [SMX_WORD_W-1:0] quo;
  } div_rsp_t;

  function automatic logic is_halting(input status_t st);
    return (st == ST_HALTED) || (st == ST_BADSTART) || (st == ST_UNDER) ||
           (st == ST_OVER) || (st == ST_DIVZERO);
  endfunction

endpackage

`default_nettype wire

// ----- hdl/smx_ram.sv -----
// operand stack memory: one port, registered synchronous read
// depends on nothing but its parameters
`default_nettype none

module smx_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = $clog2(DEPTH),
  parameter int unsigned DW    = 32
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] addr,
  input  wire logic [DW-1:0] wdata,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

// ----- hdl/smx_div.sv -----
// signed 32-bit divider, radix 2, one quotient bit per cycle, truncates toward zero
// uses smx_pkg for the request and response structs
`default_nettype none

module smx_div
  import smx_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  localparam int unsigned CNT_W = $clog2(SMX_WORD_W);

  logic                  busy;
  logic [CNT_W-1:0]      cnt;
  logic                  neg;
  logic                  done;
  logic [SMX_WORD_W-1:0] quo;
  logic [SMX_WORD_W-1:0] rem;
  logic [SMX_WORD_W-1:0] dvd;
  logic [SMX_WORD_W-1:0] dvs;
  logic [SMX_WORD_W:0]   shifted;
  logic [SMX_WORD_W:0]   diff;
  logic [SMX_WORD_W-1:0] rem_next;
  logic [SMX_WORD_W-1:0] dvd_next;

  assign rsp = '{done: done, quo: quo};

  always_comb begin
    shifted = {rem, dvd[SMX_WORD_W-1]};
    diff    = shifted - {1'b0, dvs};
    if (!diff[SMX_WORD_W]) begin
      rem_next = diff[SMX_WORD_W-1:0];
      dvd_next = {dvd[SMX_WORD_W-2:0], 1'b1};
    end else begin
      rem_next = shifted[SMX_WORD_W-1:0];
      dvd_next = {dvd[SMX_WORD_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(SMX_WORD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath, magnitudes in and sign fixed on the last step
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      dvd <= req.num[SMX_WORD_W-1] ? (~req.num + 1'b1) : req.num;
      dvs <= req.den[SMX_WORD_W-1] ? (~req.den + 1'b1) : req.den;
      neg <= req.num[SMX_WORD_W-1] ^ req.den[SMX_WORD_W-1];
    end else if (busy) begin
      rem <= rem_next;
      dvd <= dvd_next;
      if (cnt == CNT_W'(SMX_WORD_W - 1)) begin
        quo <= neg ? (~dvd_next + 1'b1) : dvd_next;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hdl/smx_core.sv -----
// sequencer of the stack machine: decode, stack memory read-modify-write, result register
// uses smx_pkg; drives smx_ram and smx_div from the top level
`default_nettype none

module smx_core
  import smx_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = SMX_STACK_DEPTH,
  parameter int unsigned AW          = $clog2(STACK_DEPTH),
  parameter int unsigned CW          = $clog2(STACK_DEPTH + 1)
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // input side
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [SMX_WORD_W-1:0] in_word,
  input  wire logic [SMX_WORD_W-1:0] in_value,
  input  wire logic                  in_start,
  // result side
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output status_t                    out_status,
  output logic      [SMX_WORD_W-1:0] out_shown,
  output logic                       out_halted,
  // stack memory
  output logic                       ram_we,
  output logic      [AW-1:0]         ram_addr,
  output logic      [SMX_WORD_W-1:0] ram_wdata,
  input  wire logic [SMX_WORD_W-1:0] ram_rdata,
  // divider
  output div_req_t                   div_req,
  input  wire div_rsp_t              div_rsp
);

  state_t                state, state_next;
  phase_t                phase;
  logic [CW-1:0]         count;
  logic [SMX_WORD_W-1:0] word;
  logic [SMX_WORD_W-1:0] inval;
  logic                  start;
  logic [SMX_WORD_W-1:0] opb;
  logic [SMX_WORD_W-1:0] res;
  status_t               status;
  logic [SMX_WORD_W-1:0] shown;

  logic          full;
  logic          fresh;
  logic          is_binop;
  logic [CW-1:0] top_idx;
  logic [CW-1:0] sec_idx;
  logic          out_free;

  assign full     = (count == CW'(STACK_DEPTH));
  assign fresh    = start || (phase == PH_FIRST);
  assign is_binop = (word == OP_ADD) || (word == OP_SUB) ||
                    (word == OP_MUL) || (word == OP_DIV);
  assign top_idx  = count - CW'(1);
  assign sec_idx  = count - CW'(2);
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and memory / divider strobes
  always_comb begin
    state_next    = state;
    ram_we        = 1'b0;
    ram_addr      = count[AW-1:0];
    ram_wdata     = (phase == PH_LITERAL) ? word : inval;
    div_req.start = 1'b0;
    div_req.num   = ram_rdata;
    div_req.den   = opb;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_FINISH;
        if (!fresh && (phase == PH_LITERAL)) begin
          ram_we = !full;
        end else if (!fresh && (phase == PH_COMMAND)) begin
          if (word == OP_IN) begin
            ram_we = !full;
          end else if (is_binop && (count >= CW'(2))) begin
            ram_addr   = top_idx[AW-1:0];
            state_next = S_RD_TOP;
          end else if ((word == OP_PRINT) && (count != '0)) begin
            ram_addr   = top_idx[AW-1:0];
            state_next = S_RD_TOP;
          end
        end
      end
      S_RD_TOP: begin
        ram_addr   = sec_idx[AW-1:0];
        state_next = (word == OP_PRINT) ? S_FINISH : S_EXEC;
      end
      S_EXEC: begin
        if (word == OP_DIV) begin
          if (opb == '0) begin
            state_next = S_FINISH;
          end else begin
            div_req.start = 1'b1;
            state_next    = S_DIV;
          end
        end else begin
          state_next = S_WB;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          state_next = S_WB;
        end
      end
      S_WB: begin
        ram_we     = 1'b1;
        ram_addr   = sec_idx[AW-1:0];
        ram_wdata  = res;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // stack pointer and phase
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_FIRST;
      count <= '0;
    end else begin
      case (state)
        S_DECODE: begin
          if (fresh) begin
            count <= '0;
            if (word == OP_PUSH) begin
              phase <= PH_LITERAL;
            end
          end else if (phase == PH_LITERAL) begin
            phase <= PH_COMMAND;
            if (!full) begin
              count <= count + CW'(1);
            end
          end else if (phase == PH_COMMAND) begin
            if (word == OP_PUSH) begin
              phase <= PH_LITERAL;
            end else if ((word == OP_IN) && !full) begin
              count <= count + CW'(1);
            end
          end
        end
        S_WB: begin
          count <= top_idx;
        end
        S_FINISH: begin
          if (out_free && is_halting(status)) begin
            phase <= PH_HALT;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        word  <= in_word;
        inval <= in_value;
        start <= in_start;
      end
      S_DECODE: begin
        shown  <= '0;
        status <= ST_OK;
        if (fresh) begin
          if (word != OP_PUSH) begin
            status <= ST_BADSTART;
          end
        end else if (phase == PH_HALT) begin
          status <= ST_HALTED;
        end else if (phase == PH_LITERAL) begin
          if (full) begin
            status <= ST_OVER;
          end
        end else begin
          case (word)
            OP_PUSH: status <= ST_OK;
            OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
              if (count < CW'(2)) begin
                status <= ST_UNDER;
              end
            end
            OP_IN: begin
              if (full) begin
                status <= ST_OVER;
              end
            end
            OP_PRINT: begin
              if (count == '0) begin
                status <= ST_UNDER;
              end
            end
            OP_OUT:  status <= ST_HALTED;
            default: status <= ST_IGNORED;
          endcase
        end
      end
      S_RD_TOP: begin
        opb <= ram_rdata;
        if (word == OP_PRINT) begin
          shown  <= ram_rdata;
          status <= ST_PRINTED;
        end
      end
      S_EXEC: begin
        // ram_rdata holds the second operand here
        case (word)
          OP_ADD:  res <= ram_rdata + opb;
          OP_SUB:  res <= ram_rdata - opb;
          OP_MUL:  res <= ram_rdata * opb;
          default: res <= '0;
        endcase
        if ((word == OP_DIV) && (opb == '0)) begin
          status <= ST_DIVZERO;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          res <= div_rsp.quo;
        end
      end
      default: begin
      end
    endcase
  end

  // result register, frees the input side while a result waits
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_FINISH) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_FINISH) && out_free) begin
      out_status <= status;
      out_shown  <= shown;
      out_halted <= is_halting(status);
    end
  end

endmodule

`default_nettype wire

// ----- hdl/stack_machine_executor_top.sv -----
// Stack machine executor: takes one 32-bit program word per input transfer and
// returns one result transfer per word. The operand stack lives in a one-port
// synchronous memory of STACK_DEPTH entries; binary opcodes read the two top
// entries in consecutive cycles and write the result back, so accesses never
// overlap and no forwarding is needed. Words are taken one at a time. A word
// that needs no stack read (PUSH, literals, IN, OUT, ignored codes, bad start,
// overflow, underflow) goes from decode to finish; PRINT reads the top entry;
// ADD, SUB and MUL read both operands, execute and write back; DIV also waits
// for the radix-2 divider, one quotient bit per cycle, unless the divisor is
// zero. A new word is taken while the previous result waits in the output
// register; a second finished result waits until that register is free.
// depends on smx_pkg, smx_ram, smx_div, smx_core and the macro header
`default_nettype none

`include "stack_machine_executor_top_macros.svh"

module stack_machine_executor_top
  import smx_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = SMX_STACK_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,  // [31:0] program_word, [63:32] in_value
  input  wire logic        s_axis_tuser,  // [0] program_start
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [31:0] m_axis_tdata,  // [31:0] shown_value
  output logic      [3:0]  m_axis_tuser   // [2:0] status, [3] halted
);

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  logic                  ram_we;
  logic [AW-1:0]         ram_addr;
  logic [SMX_WORD_W-1:0] ram_wdata;
  logic [SMX_WORD_W-1:0] ram_rdata;
  div_req_t              div_req;
  div_rsp_t              div_rsp;
  status_t               out_status;
  logic                  out_halted;

  smx_ram #(
    .DEPTH (STACK_DEPTH),
    .AW    (AW),
    .DW    (SMX_WORD_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  smx_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  smx_core #(
    .STACK_DEPTH (STACK_DEPTH),
    .AW          (AW),
    .CW          (CW)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_word    (s_axis_tdata[31:0]),
    .in_value   (s_axis_tdata[63:32]),
    .in_start   (s_axis_tuser),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_status (out_status),
    .out_shown  (m_axis_tdata),
    .out_halted (out_halted),
    .ram_we     (ram_we),
    .ram_addr   (ram_addr),
    .ram_wdata  (ram_wdata),
    .ram_rdata  (ram_rdata),
    .div_req    (div_req),
    .div_rsp    (div_rsp)
  );

  assign m_axis_tuser = {out_halted, out_status};

  // a word is decoded before the next one is taken
  `SMX_ASSERT_NEXT(a_one_word_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready, "word taken while previous still decoding")
  // the halted flag agrees with the status code
  `SMX_ASSERT_SAME(a_halted_matches, m_axis_tvalid, m_axis_tuser[3] == is_halting(status_t'(m_axis_tuser[2:0])), "halted flag disagrees with status")
  // only a print shows a value
  `SMX_ASSERT_SAME(a_shown_zero, m_axis_tvalid && (m_axis_tuser[2:0] != ST_PRINTED), m_axis_tdata == '0, "nonzero value without print")

endmodule

`default_nettype wire
